### src/rwrp_pkg.sv
// ----------------------------------------------------------------------------
// rwrp_pkg
// Shared types and constants of the register write report packer.
// ----------------------------------------------------------------------------
package rwrp_pkg;

  // field widths
  localparam int KIND_W  = 3;
  localparam int ADDR_W  = 9;
  localparam int DATA_W  = 8;
  localparam int ENTRY_W = 17;
  localparam int IDX_W   = 6;

  // stream packing
  localparam int IN_TDATA_W  = 24;  // reg_addr + reg_data, rounded to bytes
  localparam int OUT_TDATA_W = 16;  // report_byte + byte_index, rounded to bytes

  // default block sizes
  localparam int DEF_QUEUE_DEPTH  = 128;
  localparam int DEF_REPORT_BYTES = 64;

  // command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PW    = $clog2(CMD_DEPTH);
  localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

  // chip kinds that remap addresses
  localparam logic [KIND_W-1:0] KIND_OPNA  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OPN3L = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OPM   = 3'd3;

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // address ranges and remap offsets
  localparam logic [ADDR_W-1:0] EXT_LO      = 9'h100;
  localparam logic [ADDR_W-1:0] EXT_REMAP_HI = 9'h110;
  localparam logic [ADDR_W-1:0] EXT_HI      = 9'h1FB;
  localparam logic [ADDR_W-1:0] LOW_LIMIT   = 9'h0FC;
  localparam logic [ADDR_W-1:0] OPM_HI      = 9'h0FF;
  localparam logic [ADDR_W-1:0] OPNA_OFS    = 9'h040;
  localparam logic [ADDR_W-1:0] OPM_OFS     = 9'h0E0;

  // report bytes
  localparam logic [DATA_W-1:0] ESC_BYTE = 8'hFE;
  localparam logic [DATA_W-1:0] PAD_BYTE = 8'hFF;

  // byte phase within one message
  localparam logic [1:0] PH_ESC  = 2'd0;
  localparam logic [1:0] PH_ADDR = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  // command from front to back: a tick, or an encoded message
  typedef struct packed {
    logic                is_tick;
    logic [ENTRY_W-1:0]  entry;   // [16] long form, [15:8] address, [7:0] data
  } cmd_t;

  // command queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // back end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_EMIT,
    ST_PAD
  } back_state_t;

endpackage

### src/rwrp_front.sv
// ----------------------------------------------------------------------------
// rwrp_front
// Input side: holds chip kind, remaps and encodes writes, forwards ticks.
// ----------------------------------------------------------------------------
module rwrp_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rwrp_pkg::KIND_W-1:0]      cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rwrp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  rwrp_pkg::q_stat_t                q_stat,
  output logic                             push,
  output rwrp_pkg::cmd_t                   push_cmd
);
  import rwrp_pkg::*;

  logic [KIND_W-1:0] kind_r;
  logic [KIND_W-1:0] kind_nxt;
  logic [ADDR_W-1:0] reg_addr;
  logic [DATA_W-1:0] reg_data;
  logic [ADDR_W-1:0] addr_m;
  logic              keep;
  logic              xfer;

  assign cfg_ready = 1'b1;
  assign kind_nxt  = cfg_valid ? cfg_data : kind_r;

  // chip kind register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= '0;
    end else begin
      kind_r <= kind_nxt;
    end
  end

  assign reg_addr = in_tdata[ADDR_W-1:0];
  assign reg_data = in_tdata[ADDR_W+DATA_W-1:ADDR_W];

  // address remap by chip kind
  always_comb begin
    addr_m = reg_addr;
    if ((kind_r == KIND_OPNA || kind_r == KIND_OPN3L) &&
        reg_addr inside {[EXT_LO:EXT_REMAP_HI]}) begin
      addr_m = reg_addr - OPNA_OFS;
    end else if (kind_r == KIND_OPM && reg_addr inside {[LOW_LIMIT:OPM_HI]}) begin
      addr_m = reg_addr - OPM_OFS;
    end
  end

  // message encode
  always_comb begin
    keep           = 1'b0;
    push_cmd.is_tick = (in_tuser == ACT_TICK);
    push_cmd.entry = {1'b0, addr_m[7:0], reg_data};
    if (addr_m < LOW_LIMIT) begin
      keep = 1'b1;
    end else if (addr_m inside {[EXT_LO:EXT_HI]}) begin
      keep           = 1'b1;
      push_cmd.entry = {1'b1, addr_m[7:0], reg_data};
    end
  end

  // dropped writes are consumed without a queue entry
  assign in_tready = !q_stat.full;
  assign xfer      = in_tvalid && in_tready;
  assign push      = xfer && (push_cmd.is_tick || keep);

endmodule

### src/rwrp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// rwrp_cmd_fifo
// Short command queue that decouples the input side from the report sequencer.
// ----------------------------------------------------------------------------
module rwrp_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rwrp_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output rwrp_pkg::cmd_t    head,
  output rwrp_pkg::q_stat_t stat
);
  import rwrp_pkg::*;

  cmd_t              q_r [CMD_DEPTH];
  logic [CMD_PW-1:0] wp_r;
  logic [CMD_PW-1:0] wp_nxt;
  logic [CMD_PW-1:0] rp_r;
  logic [CMD_PW-1:0] rp_nxt;
  logic [CMD_CW-1:0] cnt_r;
  logic [CMD_CW-1:0] cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (cnt_r == CMD_CW'(CMD_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = q_r[rp_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  // pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == CMD_PW'(CMD_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == CMD_PW'(CMD_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= push_cmd;
    end
  end

endmodule

### src/rwrp_back.sv
// ----------------------------------------------------------------------------
// rwrp_back
// Message store and report sequencer: queues messages, packs and emits reports.
// ----------------------------------------------------------------------------
module rwrp_back #(
  parameter int QUEUE_DEPTH  = rwrp_pkg::DEF_QUEUE_DEPTH,
  parameter int REPORT_BYTES = rwrp_pkg::DEF_REPORT_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rwrp_pkg::cmd_t                    head,
  input  rwrp_pkg::q_stat_t                 q_stat,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rwrp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast
);
  import rwrp_pkg::*;

  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SZW = $clog2(REPORT_BYTES + 1);

  back_state_t        state_r;
  back_state_t        state_nxt;
  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [PW-1:0]      rd_ptr_r;
  logic [PW-1:0]      rd_ptr_nxt;
  logic [PW-1:0]      wr_ptr_r;
  logic [PW-1:0]      wr_ptr_nxt;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [SZW-1:0]     sz_r;
  logic [SZW-1:0]     sz_nxt;
  logic [1:0]         phase_r;
  logic [1:0]         phase_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [DATA_W-1:0]  out_byte_r;
  logic [DATA_W-1:0]  out_byte_nxt;
  logic [IDX_W-1:0]   out_idx_r;
  logic [IDX_W-1:0]   out_idx_nxt;
  logic               out_last_r;
  logic               out_last_nxt;

  logic               mem_wr;
  logic               mem_rd;
  logic               take;
  logic               emit_req;
  logic [DATA_W-1:0]  emit_byte;
  logic               out_load;
  logic               overflow;
  logic [SZW:0]       msg_len;
  logic               store_full;
  logic               store_empty;
  logic               at_end;
  logic               last_slot;

  assign store_full  = (count_r == CW'(QUEUE_DEPTH));
  assign store_empty = (count_r == '0);
  assign at_end      = (sz_r == SZW'(REPORT_BYTES));
  assign last_slot   = (sz_r == SZW'(REPORT_BYTES - 1));
  assign msg_len     = rd_data_r[ENTRY_W-1] ? (SZW+1)'(3) : (SZW+1)'(2);
  assign overflow    = ({1'b0, sz_r} + msg_len) > (SZW+1)'(REPORT_BYTES);
  assign out_load    = emit_req && (!out_valid_r || out_tready);

  // sequencer control outputs
  always_comb begin
    pop       = 1'b0;
    mem_wr    = 1'b0;
    mem_rd    = 1'b0;
    take      = 1'b0;
    emit_req  = 1'b0;
    emit_byte = PAD_BYTE;
    case (state_r)
      ST_IDLE: begin
        pop    = !q_stat.empty;
        mem_wr = !q_stat.empty && !head.is_tick && !store_full;
      end
      ST_READ: begin
        mem_rd = !at_end && !store_empty;
      end
      ST_CHECK: begin
        take = !overflow;
      end
      ST_EMIT: begin
        emit_req = 1'b1;
        case (phase_r)
          PH_ESC:  emit_byte = ESC_BYTE;
          PH_ADDR: emit_byte = rd_data_r[15:8];
          default: emit_byte = rd_data_r[7:0];
        endcase
      end
      ST_PAD: begin
        emit_req = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty && head.is_tick && !store_empty) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (at_end) begin
          state_nxt = ST_IDLE;
        end else if (store_empty) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = overflow ? ST_PAD : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load && phase_r == PH_DATA) begin
          state_nxt = ST_READ;
        end
      end
      ST_PAD: begin
        if (out_load && last_slot) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // pointers, fill count, report position and output register
  always_comb begin
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    count_nxt     = count_r;
    sz_nxt        = sz_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    if (mem_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      count_nxt  = count_r + 1'b1;
    end
    if (take) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_nxt  = count_r - 1'b1;
      phase_nxt  = rd_data_r[ENTRY_W-1] ? PH_ESC : PH_ADDR;
    end
    if (state_r == ST_IDLE) begin
      sz_nxt = '0;
    end
    if (out_load) begin
      sz_nxt        = sz_r + 1'b1;
      phase_nxt     = phase_r + 1'b1;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_idx_nxt   = IDX_W'(sz_r);
      out_last_nxt  = last_slot;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      count_r     <= '0;
      sz_r        <= '0;
      phase_r     <= PH_ESC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      count_r     <= count_nxt;
      sz_r        <= sz_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  // message store, registered read
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[wr_ptr_r] <= head.entry;
    end
    if (mem_rd) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_TDATA_W - IDX_W - DATA_W)'(0), out_idx_r, out_byte_r};

endmodule

### src/register_write_report_packer_core.sv
// ----------------------------------------------------------------------------
// register_write_report_packer_core
// Packs sound-chip register writes into fixed-size byte reports on tick.
// ----------------------------------------------------------------------------
// Writes are remapped by chip kind, encoded into 2- or 3-byte messages and
// kept in a message store of QUEUE_DEPTH entries; writes with an address
// that does not encode, or that arrive while the store is full, are
// dropped. Input transfers pass into a four-entry command queue, so a write
// is taken every cycle while the queue has room; the sequencer stores one
// write per cycle while it is idle. A tick on a non-empty store emits one
// report of REPORT_BYTES bytes, whole messages in order and 0xFF padding,
// one byte per output transfer. Each message passes through a store read
// and a length check in the sequencer before its bytes go out, since the
// store has a single read port. The user must write configuration (chip
// kind) only while the block is idle; the block does not enforce it.
module register_write_report_packer_core #(
  parameter int QUEUE_DEPTH  = rwrp_pkg::DEF_QUEUE_DEPTH,
  parameter int REPORT_BYTES = rwrp_pkg::DEF_REPORT_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration: chip_kind
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rwrp_pkg::KIND_W-1:0]       cfg_data,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rwrp_pkg::IN_TDATA_W-1:0]   in_tdata,   // reg_addr[8:0], reg_data[16:9]
  input  logic                              in_tuser,   // action
  // report stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rwrp_pkg::OUT_TDATA_W-1:0]  out_tdata,  // report_byte[7:0], byte_index[13:8]
  output logic                              out_tlast   // last_byte
);
  import rwrp_pkg::*;

  cmd_t    push_cmd;
  cmd_t    head;
  q_stat_t q_stat;
  logic    push;
  logic    pop;

  // classify and encode
  rwrp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // command queue
  rwrp_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // store and report sequencer
  rwrp_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .REPORT_BYTES (REPORT_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for register_write_report_packer_core.
// ----------------------------------------------------------------------------
// Register writes and report ticks go in over the input stream. A scoreboard
// keeps its own copy of the chip kind and of the message store. It remaps
// and encodes each accepted write, and on each accepted tick it builds the
// 64-byte report it expects. Every report transfer is compared field by
// field with the oldest expected byte. A directed run covers the address
// ranges, the drop cases and each remapping chip kind. Random phases follow
// under changing chip kinds, and one phase floods the store past full. The
// sender works in random bursts and the receiver stalls in changing modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rwrp_pkg::*;

  localparam int STORE_DEPTH  = DEF_QUEUE_DEPTH;
  localparam int REPORT_LEN   = DEF_REPORT_BYTES;
  localparam int RANDOM_ITEMS = 420;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 400000;

  // chip kinds that leave addresses alone
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OPL3    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TOP     = 3'd7;

  // one expected byte of a report
  typedef struct packed {
    logic [7:0]       data;
    logic [IDX_W-1:0] pos;
    logic             last;
  } report_beat_t;

  // scoreboard: message store model and expected report bytes
  class report_scoreboard;
    logic [KIND_W-1:0]  chip_kind;
    logic [ENTRY_W-1:0] msg_fifo[$];
    report_beat_t       report_q[$];
    int                 errors;

    function new();
      chip_kind = KIND_UNKNOWN;
      errors    = 0;
    endfunction

    function int pending();
      return report_q.size();
    endfunction

    // note an accepted input transfer; returns 1 when it had any effect
    function bit note_item(logic act, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      logic [ADDR_W-1:0]  a;
      logic [ENTRY_W-1:0] entry;
      logic [7:0]         bytes_q[$];
      report_beat_t       beat;
      if (act == ACT_WRITE) begin
        a = addr;
        // remap by chip kind
        if ((chip_kind == KIND_OPNA || chip_kind == KIND_OPN3L) &&
            a >= EXT_LO && a <= EXT_REMAP_HI) begin
          a = a - OPNA_OFS;
        end else if (chip_kind == KIND_OPM && a >= LOW_LIMIT && a <= OPM_HI) begin
          a = a - OPM_OFS;
        end
        // encode as short or long message, or drop
        if (a < LOW_LIMIT) begin
          entry = {1'b0, a[7:0], data};
        end else if (a >= EXT_LO && a <= EXT_HI) begin
          entry = {1'b1, a[7:0], data};
        end else begin
          return 1'b0;
        end
        if (msg_fifo.size() >= STORE_DEPTH) return 1'b0;
        msg_fifo = {msg_fifo, entry};
        return 1'b1;
      end
      // tick on empty store gives nothing
      if (msg_fifo.size() == 0) return 1'b0;
      // pack whole messages while they fit
      while (msg_fifo.size() > 0) begin
        entry = msg_fifo[0];
        if (bytes_q.size() + (entry[16] ? 3 : 2) > REPORT_LEN) break;
        if (entry[16]) bytes_q = {bytes_q, ESC_BYTE};
        bytes_q = {bytes_q, entry[15:8]};
        bytes_q = {bytes_q, entry[7:0]};
        void'(msg_fifo.pop_front());
      end
      while (bytes_q.size() < REPORT_LEN) bytes_q = {bytes_q, PAD_BYTE};
      for (int i = 0; i < REPORT_LEN; i++) begin
        beat.data = bytes_q[i];
        beat.pos  = i[IDX_W-1:0];
        beat.last = (i == REPORT_LEN - 1);
        report_q = {report_q, beat};
      end
      return 1'b1;
    endfunction

    // check one report transfer against the oldest expected byte
    function void check_beat(logic [7:0] data, logic [IDX_W-1:0] pos, logic last);
      report_beat_t want;
      if (report_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected report byte %02h pos %0d last %0b", data, pos, last);
        return;
      end
      want = report_q.pop_front();
      if (want.data !== data || want.pos !== pos || want.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("report mismatch: expected byte %02h pos %0d last %0b, got %02h %0d %0b",
                   want.data, want.pos, want.last, data, pos, last);
      end
    endfunction
  endclass

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    cfg_valid  = 1'b0;
  logic                    cfg_ready;
  logic [KIND_W-1:0]       cfg_data   = '0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;  // reg_addr[8:0], reg_data[16:9]
  logic                    in_tuser   = 1'b0; // action
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;        // report_byte[7:0], byte_index[13:8]
  logic                    out_tlast;        // last_byte

  report_scoreboard sb = new();

  int burst_left = 0;
  bit no_idle    = 1'b0;
  int counted    = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  register_write_report_packer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("[register_write_report_packer_core] ERROR");
    $finish;
  end

  // receiver: stall pattern and report check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_beat(out_tdata[7:0], out_tdata[13:8], out_tlast);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(40, 200);
    end
    stall_left--;
    stall_tick++;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 4) == 0);
        default: out_tready <= (stall_tick[2:0] != 3'd0);
      endcase
    end
  end

  // one input transfer, with burst gaps
  task automatic send_item(input logic act, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = no_idle ? 100000 : $urandom_range(1, 24);
    end
    in_tuser  <= act;
    in_tdata  <= {7'd0, data, addr};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    void'(sb.note_item(act, addr, data));
    counted++;
  endtask

  // let every expected byte arrive and the block settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // chip kind register transfer
  task automatic set_kind(input logic [KIND_W-1:0] kind);
    cfg_data  <= kind;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.chip_kind = kind;
  endtask

  // random address, weighted toward the range edges
  function automatic logic [ADDR_W-1:0] pick_addr();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return ADDR_W'($urandom_range(0, 'h0FB));
      4:          return ADDR_W'($urandom_range('h0FC, 'h0FF));
      5:          return ADDR_W'($urandom_range('h100, 'h110));
      6, 7:       return ADDR_W'($urandom_range('h111, 'h1FB));
      8:          return ADDR_W'($urandom_range('h1FC, 'h1FF));
      default:    return ADDR_W'($urandom_range(0, 'h1FF));
    endcase
  endfunction

  // stimulus
  initial begin
    logic [KIND_W-1:0] kind_order[6];
    logic [KIND_W-1:0] kind;
    int                phase;
    int                len;
    bit                flood;
    kind_order = '{KIND_TOP, KIND_OPNA, KIND_UNKNOWN, KIND_OPM, KIND_OPN3L, KIND_OPL3};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: address ranges and drops with no remap
    send_item(ACT_TICK,  9'h1FF, 8'hFF);
    send_item(ACT_WRITE, 9'h000, 8'h00);
    send_item(ACT_WRITE, 9'h0FB, 8'hFF);
    send_item(ACT_WRITE, 9'h0FC, 8'h11);
    send_item(ACT_WRITE, 9'h0FF, 8'h22);
    send_item(ACT_WRITE, 9'h100, 8'h55);
    send_item(ACT_WRITE, 9'h1FB, 8'hAA);
    send_item(ACT_WRITE, 9'h1FC, 8'h33);
    send_item(ACT_WRITE, 9'h1FF, 8'h44);
    send_item(ACT_WRITE, 9'h110, 8'h66);
    send_item(ACT_TICK,  9'h000, 8'h00);
    wait_idle();
    // opna remap window and its edges
    set_kind(KIND_OPNA);
    send_item(ACT_WRITE, 9'h100, 8'h01);
    send_item(ACT_WRITE, 9'h110, 8'h02);
    send_item(ACT_WRITE, 9'h111, 8'h03);
    send_item(ACT_WRITE, 9'h0FE, 8'h04);
    send_item(ACT_TICK,  9'h155, 8'hA5);
    wait_idle();
    // opm remap of the top low addresses
    set_kind(KIND_OPM);
    send_item(ACT_WRITE, 9'h0FC, 8'h05);
    send_item(ACT_WRITE, 9'h0FF, 8'h06);
    send_item(ACT_WRITE, 9'h100, 8'h07);
    send_item(ACT_WRITE, 9'h0FB, 8'h08);
    send_item(ACT_TICK,  9'h0AA, 8'h5A);
    wait_idle();
    set_kind(KIND_OPN3L);
    send_item(ACT_WRITE, 9'h105, 8'h09);
    send_item(ACT_TICK,  9'h000, 8'hFF);
    wait_idle();

    // random phases, each under one chip kind
    counted = 0;
    phase   = 0;
    while (counted < RANDOM_ITEMS) begin
      kind = (phase < 6) ? kind_order[phase] : KIND_W'($urandom_range(0, 7));
      set_kind(kind);
      flood   = (phase == 2);
      no_idle = ($urandom_range(0, 3) == 0);
      if (flood) begin
        // overfill the store, then drain it with ticks
        for (int i = 0; i < 160; i++)
          send_item(ACT_WRITE, ADDR_W'($urandom_range(0, 'h0FB)),
                    DATA_W'($urandom_range(0, 255)));
        for (int i = 0; i < 6; i++)
          send_item(ACT_TICK, ADDR_W'($urandom_range(0, 'h1FF)),
                    DATA_W'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(20, 70);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 11) == 0)
            send_item(ACT_TICK, ADDR_W'($urandom_range(0, 'h1FF)),
                      DATA_W'($urandom_range(0, 255)));
          else
            send_item(ACT_WRITE, pick_addr(), DATA_W'($urandom_range(0, 255)));
        end
        send_item(ACT_TICK, ADDR_W'($urandom_range(0, 'h1FF)),
                  DATA_W'($urandom_range(0, 255)));
      end
      no_idle = 1'b0;
      wait_idle();
      phase++;
    end

    repeat (2 * REPORT_LEN) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[register_write_report_packer_core] OK");
    end else begin
      $display("[register_write_report_packer_core] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
src/rwrp_pkg.sv
src/rwrp_front.sv
src/rwrp_cmd_fifo.sv
src/rwrp_back.sv
src/register_write_report_packer_core.sv
verif/tb.sv
